@@ src/mlr_pkg.sv @@
// Shared types and codes for the midpoint line rasterizer.
// Beat structs for both channels, operation codes and line mode codes.
// No dependencies.
package mlr_pkg;

   localparam int FIELD_BITS = 12;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic [2:0] MODE_HORZ    = 3'd0;
   localparam logic [2:0] MODE_VERT    = 3'd1;
   localparam logic [2:0] MODE_XM_RISE = 3'd2;
   localparam logic [2:0] MODE_XM_FALL = 3'd3;
   localparam logic [2:0] MODE_YM_RISE = 3'd4;
   localparam logic [2:0] MODE_YM_FALL = 3'd5;

   typedef struct packed {
      logic                  operation;
      logic [FIELD_BITS-1:0] x_start;
      logic [FIELD_BITS-1:0] y_start;
      logic [FIELD_BITS-1:0] x_end;
      logic [FIELD_BITS-1:0] y_end;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pixel_x;
      logic [FIELD_BITS-1:0] pixel_y;
      logic                  pixel_valid;
      logic                  last_pixel;
   } rsp_type;

endpackage

@@ src/mlr_walker.sv @@
// Line state and per-beat logic: segment setup on load, midpoint step on step.
// Depends on mlr_pkg for beat types, operation and mode codes.
module mlr_walker #(
   parameter int COORD_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  mlr_pkg::req_type item,
   output mlr_pkg::rsp_type rsp,
   output logic             has_rsp
);

   localparam int CB = COORD_BITS;
   localparam int AW = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 4;

   logic [CB-1:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CB-1:0]        stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   logic signed [DW-1:0] decision_ff, decision_in;
   logic signed [AW-1:0] coeff_a_ff, coeff_a_in, coeff_b_ff, coeff_b_in;
   logic [2:0]           mode_ff, mode_in;
   logic                 active_ff, active_in;

   logic [CB-1:0]        xs, ys, xe, ye, x1, y1, x2, y2;
   logic                 swap;
   logic signed [AW-1:0] ld_a, ld_b, ld_mag;
   logic signed [DW-1:0] ld_a_ext, ld_b_ext;
   logic signed [DW-1:0] a_ext, b_ext, a2, b2;
   logic [CB-1:0]        inc_x, inc_y, dec_y;
   logic                 y_major, last, dec_neg, dec_zero;

   always_comb begin
      xs   = CB'(item.x_start);
      ys   = CB'(item.y_start);
      xe   = CB'(item.x_end);
      ye   = CB'(item.y_end);
      swap = xs > xe;
      x1   = swap ? xe : xs;
      y1   = swap ? ye : ys;
      x2   = swap ? xs : xe;
      y2   = swap ? ys : ye;
      ld_a = $signed({1'b0, y1}) - $signed({1'b0, y2});
      ld_b = $signed({1'b0, x2}) - $signed({1'b0, x1});
      ld_mag   = ld_a[AW-1] ? -ld_a : ld_a;
      ld_a_ext = DW'(ld_a);
      ld_b_ext = DW'(ld_b);

      a_ext    = DW'(coeff_a_ff);
      b_ext    = DW'(coeff_b_ff);
      a2       = a_ext <<< 1;
      b2       = b_ext <<< 1;
      inc_x    = cur_x_ff + CB'(1);
      inc_y    = cur_y_ff + CB'(1);
      dec_y    = cur_y_ff - CB'(1);
      dec_neg  = decision_ff[DW-1];
      dec_zero = decision_ff == '0;

      y_major = (mode_ff == mlr_pkg::MODE_VERT) || (mode_ff == mlr_pkg::MODE_YM_RISE)
             || (mode_ff == mlr_pkg::MODE_YM_FALL);
      last = y_major ? (cur_y_ff == stop_y_ff) : (cur_x_ff == stop_x_ff);
      if (mode_ff > mlr_pkg::MODE_YM_FALL) last = 1'b1;
   end

   always_comb begin
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      stop_x_in   = stop_x_ff;
      stop_y_in   = stop_y_ff;
      decision_in = decision_ff;
      coeff_a_in  = coeff_a_ff;
      coeff_b_in  = coeff_b_ff;
      mode_in     = mode_ff;
      active_in   = active_ff;

      has_rsp          = fire && (item.operation == mlr_pkg::OP_STEP);
      rsp.pixel_x      = '0;
      rsp.pixel_y      = '0;
      rsp.pixel_valid  = 1'b0;
      rsp.last_pixel   = 1'b0;

      if (fire && item.operation == mlr_pkg::OP_LOAD) begin
         coeff_a_in  = ld_a;
         coeff_b_in  = ld_b;
         cur_x_in    = x1;
         cur_y_in    = y1;
         stop_x_in   = x2;
         stop_y_in   = y2;
         decision_in = '0;
         active_in   = 1'b1;
         if (ld_a == '0) begin
            mode_in = mlr_pkg::MODE_HORZ;
         end else if (ld_b == '0) begin
            mode_in = mlr_pkg::MODE_VERT;
            if (y1 > y2) begin
               cur_y_in  = y2;
               stop_y_in = y1;
            end
         end else if (ld_mag <= ld_b) begin
            if (ld_a[AW-1]) begin
               mode_in     = mlr_pkg::MODE_XM_RISE;
               decision_in = (ld_a_ext <<< 1) + ld_b_ext;
            end else begin
               mode_in     = mlr_pkg::MODE_XM_FALL;
               decision_in = (ld_a_ext <<< 1) - ld_b_ext;
            end
         end else begin
            if (ld_a[AW-1]) begin
               mode_in     = mlr_pkg::MODE_YM_RISE;
               decision_in = ld_a_ext + (ld_b_ext <<< 1);
            end else begin
               mode_in     = mlr_pkg::MODE_YM_FALL;
               decision_in = ld_a_ext - (ld_b_ext <<< 1);
            end
         end
      end else if (has_rsp && active_ff) begin
         rsp.pixel_x     = mlr_pkg::FIELD_BITS'(cur_x_ff);
         rsp.pixel_y     = mlr_pkg::FIELD_BITS'(cur_y_ff);
         rsp.pixel_valid = 1'b1;
         rsp.last_pixel  = last;
         if (last) begin
            active_in = 1'b0;
         end else begin
            unique case (mode_ff)
               mlr_pkg::MODE_HORZ: cur_x_in = inc_x;
               mlr_pkg::MODE_VERT: cur_y_in = inc_y;
               mlr_pkg::MODE_XM_RISE: begin
                  cur_x_in = inc_x;
                  if (!dec_neg) begin
                     decision_in = decision_ff + a2;
                  end else begin
                     cur_y_in    = inc_y;
                     decision_in = decision_ff + a2 + b2;
                  end
               end
               mlr_pkg::MODE_XM_FALL: begin
                  cur_x_in = inc_x;
                  if (!dec_neg) begin
                     cur_y_in    = dec_y;
                     decision_in = decision_ff + a2 - b2;
                  end else begin
                     decision_in = decision_ff + a2;
                  end
               end
               mlr_pkg::MODE_YM_RISE: begin
                  cur_y_in = inc_y;
                  if (!dec_neg && !dec_zero) begin
                     cur_x_in    = inc_x;
                     decision_in = decision_ff + a2 + b2;
                  end else begin
                     decision_in = decision_ff + b2;
                  end
               end
               mlr_pkg::MODE_YM_FALL: begin
                  cur_y_in = dec_y;
                  if (!dec_neg && !dec_zero) begin
                     decision_in = decision_ff - b2;
                  end else begin
                     cur_x_in    = inc_x;
                     decision_in = decision_ff + a2 - b2;
                  end
               end
               default: active_in = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         mode_ff   <= mlr_pkg::MODE_HORZ;
      end else begin
         active_ff <= active_in;
         mode_ff   <= mode_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      stop_x_ff   <= stop_x_in;
      stop_y_ff   <= stop_y_in;
      decision_ff <= decision_in;
      coeff_a_ff  <= coeff_a_in;
      coeff_b_ff  <= coeff_b_in;
   end

endmodule

@@ src/midpoint_line_rasterizer_unit.sv @@
// Top level of the midpoint line rasterizer: input beat register, line walker,
// result register. Depends on mlr_pkg and mlr_walker.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | mlr_pkg::req_type
//   rsp     | out       | rsp_valid/stall   | mlr_pkg::rsp_type
//
// One beat per clock unless the result stalls; a step result is registered.
// The rate is set by the combinational midpoint update of the walker state.
// Load beats give no result; a step beat gives exactly one.
// Reset clears the valid flags and the active line; no line is active after it.
// A stalled result holds in its register; input stalls only while that is full.
module midpoint_line_rasterizer_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mlr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mlr_pkg::rsp_type rsp_data
);

   mlr_pkg::req_type in_ff;
   logic             in_valid_ff;
   mlr_pkg::rsp_type rsp_ff, step_rsp;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free, fire, has_rsp;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_free;
   assign fire      = in_valid_ff && out_free;

   mlr_walker #(.COORD_BITS(COORD_BITS)) u_walker (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (in_ff),
      .rsp     (step_rsp),
      .has_rsp (has_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (has_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (!req_stall) in_ff <= req_data;
      if (has_rsp) rsp_ff <= step_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      fire && in_ff.operation == mlr_pkg::OP_LOAD |=> !rsp_valid_ff)
      else $error("load beat produced a result");

   a_step_rsp: assert property (@(posedge clock) disable iff (reset)
      fire && in_ff.operation == mlr_pkg::OP_STEP |=> rsp_valid_ff)
      else $error("step beat produced no result");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_pixel |-> rsp_ff.pixel_valid)
      else $error("last flag on an invalid pixel");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.pixel_valid |-> rsp_ff.pixel_x == '0 && rsp_ff.pixel_y == '0)
      else $error("invalid pixel carries coordinates");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled with nothing pending");

endmodule

@@ bench/mlr_pixel_checker.sv @@
// Pixel checker for the midpoint line rasterizer: watches the req and rsp channels,
// keeps its own line walker to predict each step beat and compares results in order.
// Depends on mlr_pkg.
module mlr_pixel_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  mlr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  mlr_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [mlr_pkg::FIELD_BITS-1:0] walk_x, walk_y, end_x, end_y;
   logic signed [15:0]             midpoint_err;
   logic signed [12:0]             delta_a, delta_b;
   logic [2:0]                     walk_mode;
   logic                           walking;
   mlr_pkg::rsp_type               expected_pixels[16];
   logic [3:0]                     queue_head, queue_tail;
   int                             queued;
   int                             mismatches = 0;

   function automatic void start_segment(input mlr_pkg::req_type beat);
      logic [mlr_pkg::FIELD_BITS-1:0] x1, y1, x2, y2;
      logic signed [12:0]             mag;
      x1 = beat.x_start;
      y1 = beat.y_start;
      x2 = beat.x_end;
      y2 = beat.y_end;
      if (x1 > x2) begin
         x1 = beat.x_end;
         y1 = beat.y_end;
         x2 = beat.x_start;
         y2 = beat.y_start;
      end
      delta_a      = $signed({1'b0, y1}) - $signed({1'b0, y2});
      delta_b      = $signed({1'b0, x2 - x1});
      mag          = (delta_a < 0) ? -delta_a : delta_a;
      walk_x       = x1;
      walk_y       = y1;
      end_x        = x2;
      end_y        = y2;
      midpoint_err = '0;
      if (delta_a == 0) begin
         walk_mode = mlr_pkg::MODE_HORZ;
      end else if (delta_b == 0) begin
         walk_mode = mlr_pkg::MODE_VERT;
         if (y1 > y2) begin
            walk_y = y2;
            end_y  = y1;
         end
      end else if (mag <= delta_b) begin
         if (delta_a < 0) begin
            walk_mode    = mlr_pkg::MODE_XM_RISE;
            midpoint_err = 16'(2 * delta_a + delta_b);
         end else begin
            walk_mode    = mlr_pkg::MODE_XM_FALL;
            midpoint_err = 16'(2 * delta_a - delta_b);
         end
      end else begin
         if (delta_a < 0) begin
            walk_mode    = mlr_pkg::MODE_YM_RISE;
            midpoint_err = 16'(delta_a + 2 * delta_b);
         end else begin
            walk_mode    = mlr_pkg::MODE_YM_FALL;
            midpoint_err = 16'(delta_a - 2 * delta_b);
         end
      end
      walking = 1'b1;
   endfunction

   function automatic mlr_pkg::rsp_type next_pixel();
      mlr_pkg::rsp_type pix;
      logic             y_major;
      pix = '0;
      if (!walking) return pix;
      y_major = (walk_mode == mlr_pkg::MODE_VERT) || (walk_mode == mlr_pkg::MODE_YM_RISE) ||
                (walk_mode == mlr_pkg::MODE_YM_FALL);
      pix.pixel_x     = walk_x;
      pix.pixel_y     = walk_y;
      pix.pixel_valid = 1'b1;
      pix.last_pixel  = y_major ? (walk_y == end_y) : (walk_x == end_x);
      if (walk_mode > mlr_pkg::MODE_YM_FALL) pix.last_pixel = 1'b1;
      if (pix.last_pixel) begin
         walking = 1'b0;
         return pix;
      end
      case (walk_mode)
         mlr_pkg::MODE_HORZ: begin
            walk_x = walk_x + 1'b1;
         end
         mlr_pkg::MODE_VERT: begin
            walk_y = walk_y + 1'b1;
         end
         mlr_pkg::MODE_XM_RISE: begin
            walk_x = walk_x + 1'b1;
            if (midpoint_err >= 0) begin
               midpoint_err = 16'(midpoint_err + 2 * delta_a);
            end else begin
               walk_y       = walk_y + 1'b1;
               midpoint_err = 16'(midpoint_err + 2 * delta_a + 2 * delta_b);
            end
         end
         mlr_pkg::MODE_XM_FALL: begin
            walk_x = walk_x + 1'b1;
            if (midpoint_err >= 0) begin
               walk_y       = walk_y - 1'b1;
               midpoint_err = 16'(midpoint_err + 2 * delta_a - 2 * delta_b);
            end else begin
               midpoint_err = 16'(midpoint_err + 2 * delta_a);
            end
         end
         mlr_pkg::MODE_YM_RISE: begin
            walk_y = walk_y + 1'b1;
            if (midpoint_err > 0) begin
               walk_x       = walk_x + 1'b1;
               midpoint_err = 16'(midpoint_err + 2 * delta_a + 2 * delta_b);
            end else begin
               midpoint_err = 16'(midpoint_err + 2 * delta_b);
            end
         end
         mlr_pkg::MODE_YM_FALL: begin
            walk_y = walk_y - 1'b1;
            if (midpoint_err > 0) begin
               midpoint_err = 16'(midpoint_err - 2 * delta_b);
            end else begin
               walk_x       = walk_x + 1'b1;
               midpoint_err = 16'(midpoint_err + 2 * delta_a - 2 * delta_b);
            end
         end
         default: begin
            walking = 1'b0;
         end
      endcase
      return pix;
   endfunction

   always @(posedge clock) begin
      mlr_pkg::rsp_type want;
      if (reset) begin
         walk_x       = '0;
         walk_y       = '0;
         end_x        = '0;
         end_y        = '0;
         midpoint_err = '0;
         delta_a      = '0;
         delta_b      = '0;
         walk_mode    = mlr_pkg::MODE_HORZ;
         walking      = 1'b0;
         queue_head   = '0;
         queue_tail   = '0;
         queued       = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.operation == mlr_pkg::OP_LOAD) begin
               start_segment(req_data);
            end else begin
               expected_pixels[queue_tail] = next_pixel();
               queue_tail = queue_tail + 4'd1;
               queued++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (queued == 0) begin
               mismatches++;
               $display("%0t: unexpected pixel beat, expected none, got x=%0d y=%0d %s",
                        $time, rsp_data.pixel_x, rsp_data.pixel_y,
                        $sformatf("valid=%0b last=%0b", rsp_data.pixel_valid,
                                  rsp_data.last_pixel));
            end else begin
               want       = expected_pixels[queue_head];
               queue_head = queue_head + 4'd1;
               queued--;
               if (rsp_data.pixel_x !== want.pixel_x || rsp_data.pixel_y !== want.pixel_y ||
                   rsp_data.pixel_valid !== want.pixel_valid ||
                   rsp_data.last_pixel !== want.last_pixel) begin
                  mismatches++;
                  $display("%0t: pixel mismatch, expected x=%0d y=%0d valid=%0b last=%0b,",
                           $time, want.pixel_x, want.pixel_y, want.pixel_valid,
                           want.last_pixel);
                  $display("   got x=%0d y=%0d valid=%0b last=%0b",
                           rsp_data.pixel_x, rsp_data.pixel_y,
                           rsp_data.pixel_valid, rsp_data.last_pixel);
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= queued;
   end

endmodule

@@ bench/tb_midpoint_line_rasterizer_unit.sv @@
// Top of the midpoint line rasterizer testbench: clock, reset, segment and step stimulus
// with random gaps and stalls, and the verdict. Depends on mlr_pkg,
// midpoint_line_rasterizer_unit and mlr_pixel_checker.
module tb_midpoint_line_rasterizer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;
   localparam int COORD_MAX   = (1 << mlr_pkg::FIELD_BITS) - 1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mlr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mlr_pkg::rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int sent_count  = 0;
   int stall_left  = 0;
   bit sender_gaps   = 1'b0;
   bit receiver_gaps = 1'b0;

   midpoint_line_rasterizer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   mlr_pixel_checker pixel_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!reset && receiver_gaps && $urandom_range(0, 6) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic drive_beat(input mlr_pkg::req_type beat);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic load_line(input int xs, input int ys, input int xe, input int ye);
      mlr_pkg::req_type beat;
      beat.operation = mlr_pkg::OP_LOAD;
      beat.x_start   = xs[mlr_pkg::FIELD_BITS-1:0];
      beat.y_start   = ys[mlr_pkg::FIELD_BITS-1:0];
      beat.x_end     = xe[mlr_pkg::FIELD_BITS-1:0];
      beat.y_end     = ye[mlr_pkg::FIELD_BITS-1:0];
      drive_beat(beat);
   endtask

   task automatic step_line(input int count);
      mlr_pkg::req_type beat;
      repeat (count) begin
         beat.operation = mlr_pkg::OP_STEP;
         beat.x_start   = mlr_pkg::FIELD_BITS'($urandom_range(0, COORD_MAX));
         beat.y_start   = mlr_pkg::FIELD_BITS'($urandom_range(0, COORD_MAX));
         beat.x_end     = mlr_pkg::FIELD_BITS'($urandom_range(0, COORD_MAX));
         beat.y_end     = mlr_pkg::FIELD_BITS'($urandom_range(0, COORD_MAX));
         drive_beat(beat);
      end
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int               xs, ys, xe, ye, span, dx, dy, steps, pick;
      bit               paused;
      mlr_pkg::req_type junk;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      step_line(1);
      load_line(5, 7, 5, 7);
      step_line(2);
      load_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX);
      step_line(3);
      load_line(0, COORD_MAX, 0, COORD_MAX - 1);
      step_line(2);
      load_line(0, 0, 2, 1);
      step_line(3);
      load_line(2, 0, 0, 1);
      step_line(1);
      load_line(COORD_MAX - 1, 0, COORD_MAX, 2);
      step_line(3);
      load_line(0, 2, 1, 0);
      step_line(3);
      drain_pixels();

      while (sent_count < 700) begin
         if (sent_count > 600) begin
            sender_gaps   = 1'b0;
            receiver_gaps = 1'b0;
         end else begin
            sender_gaps   = $urandom_range(0, 3) != 0;
            receiver_gaps = $urandom_range(0, 3) != 0;
         end
         if (!paused && sent_count > 350) begin
            paused = 1'b1;
            drain_pixels();
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               junk.operation = 1'($urandom_range(0, 1));
               junk.x_start   = mlr_pkg::FIELD_BITS'($urandom_range(0, COORD_MAX));
               junk.y_start   = mlr_pkg::FIELD_BITS'($urandom_range(0, COORD_MAX));
               junk.x_end     = mlr_pkg::FIELD_BITS'($urandom_range(0, COORD_MAX));
               junk.y_end     = mlr_pkg::FIELD_BITS'($urandom_range(0, COORD_MAX));
               drive_beat(junk);
            end
         end else begin
            span = ($urandom_range(0, 24) == 0) ? 150 : 12;
            xs   = $urandom_range(0, COORD_MAX);
            ys   = $urandom_range(0, COORD_MAX);
            dx   = $urandom_range(0, span);
            dy   = $urandom_range(0, span);
            if ($urandom_range(0, 1)) dx = -dx;
            if ($urandom_range(0, 1)) dy = -dy;
            xe = xs + dx;
            ye = ys + dy;
            if (xe < 0) xe = 0;
            if (xe > COORD_MAX) xe = COORD_MAX;
            if (ye < 0) ye = 0;
            if (ye > COORD_MAX) ye = COORD_MAX;
            dx    = (xe > xs) ? xe - xs : xs - xe;
            dy    = (ye > ys) ? ye - ys : ys - ye;
            steps = ((dx > dy) ? dx : dy) + 1;
            pick  = $urandom_range(0, 9);
            if (pick == 0) steps = $urandom_range(1, steps);
            else if (pick == 1) steps = steps + $urandom_range(1, 2);
            load_line(xs, ys, xe, ye);
            step_line(steps);
         end
      end

      drain_pixels();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/mlr_pkg.sv
src/mlr_walker.sv
src/midpoint_line_rasterizer_unit.sv
bench/mlr_pixel_checker.sv
bench/tb_midpoint_line_rasterizer_unit.sv
